// ----- rtl/core/text_console_cursor_engine_assert.svh -----
// Assertion macros used by the console engine back end.
// Depends on nothing; included inside module bodies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define TCCE_ASSERT_ALWAYS(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("tcce: check failed");

// Antecedent implies consequent in the same cycle.
`define TCCE_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tcce: check failed");

// Antecedent implies consequent in the next cycle.
`define TCCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tcce: check failed");

`endif

// ----- rtl/core/tcce_pkg.sv -----
// Shared types and constants of the text console engine.
// Used by the front, queue, back and top level; depends on nothing.
package tcce_pkg;

  localparam int DefColumns = 80;
  localparam int DefRows    = 25;
  localparam int QueueDepth = 2;

  localparam logic [7:0] CharNewline   = 8'd10;
  localparam logic [7:0] CharBackspace = 8'd8;
  localparam logic [7:0] CharTab       = 8'd9;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] ResetAttr     = 8'h0F;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_TAB,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } op_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_EMIT
  } back_state_e;

endpackage

// ----- rtl/core/tcce_front.sv -----
// Front end of the console engine: accepts input beats and decodes them into ops.
// Depends on tcce_pkg.
module tcce_front #(
  parameter int COLUMNS = tcce_pkg::DefColumns,
  parameter int ROWS    = tcce_pkg::DefRows
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         char_code_i,
  input  logic [4:0]         read_row_i,
  input  logic [6:0]         read_col_i,
  input  logic               queue_full_i,
  input  logic               init_busy_i,
  output logic               push_o,
  output tcce_pkg::op_item_t item_o
);
  import tcce_pkg::*;

  logic read_ok;

  assign in_ready_o = !queue_full_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign read_ok    = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLUMNS);

  always_comb begin
    item_o.ch  = char_code_i;
    item_o.row = read_row_i;
    item_o.col = read_col_i;
    item_o.op  = OP_NOP;
    case (mode_i)
      MODE_PUT: begin
        case (char_code_i)
          CharNewline:   item_o.op = OP_NEWLINE;
          CharBackspace: item_o.op = OP_BACKSPACE;
          CharTab:       item_o.op = OP_TAB;
          default:       item_o.op = OP_PRINT;
        endcase
      end
      MODE_CLEAR: item_o.op = OP_CLEAR;
      MODE_READ:  item_o.op = read_ok ? OP_READ : OP_NOP;
      default:    item_o.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/core/tcce_queue.sv -----
// Short op queue between the front and back of the console engine.
// Depends on tcce_pkg.
module tcce_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tcce_pkg::op_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output tcce_pkg::op_item_t item_o
);
  import tcce_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  op_item_t        entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/core/tcce_back.sv -----
// Back end of the console engine: cursor, screen store, scroll and clear sweeps, result beat.
// Depends on tcce_pkg and text_console_cursor_engine_assert.svh.
module tcce_back #(
  parameter int COLUMNS = tcce_pkg::DefColumns,
  parameter int ROWS    = tcce_pkg::DefRows
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         attr_i,
  input  logic               item_valid_i,
  input  tcce_pkg::op_item_t item_i,
  output logic               pop_o,
  output logic               init_busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [6:0]         cursor_col_o,
  output logic [4:0]         cursor_row_o,
  output logic [15:0]        cell_word_o,
  output logic               did_scroll_o
);
  import tcce_pkg::*;
  `include "text_console_cursor_engine_assert.svh"

  localparam int CellCount = COLUMNS * ROWS;
  localparam int AW        = $clog2(CellCount);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int ColW      = CW + 1;
  localparam int RowW      = RW + 1;

  back_state_e    state_q, state_d;
  logic [CW-1:0]  cur_col_q, cur_col_d;
  logic [RW-1:0]  cur_row_q, cur_row_d;
  logic [AW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  wa_q, wa_d;
  logic           pend_q, pend_d;
  logic           scroll_q, scroll_d;
  logic           cell_sel_q, cell_sel_d;
  logic           out_valid_q, out_valid_d;
  logic [6:0]     out_col_q, out_col_d;
  logic [4:0]     out_row_q, out_row_d;
  logic [15:0]    out_word_q, out_word_d;
  logic           out_scroll_q, out_scroll_d;

  logic [15:0]    mem_q [CellCount];
  logic [15:0]    rdata_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_wa, mem_ra;
  logic [15:0]    mem_wd;

  logic [AW-1:0]  cur_addr, bs_addr, rd_addr;
  logic [ColW-1:0] step_col;
  logic [RowW-1:0] step_row;
  logic           step_scroll;
  logic           last_cnt;
  logic           out_free;
  logic [15:0]    blank_word;

  assign last_cnt   = (cnt_q == AW'(CellCount - 1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign blank_word = {attr_i, CharSpace};
  assign cur_addr   = AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q);
  assign bs_addr    = (cur_addr == '0) ? '0 : cur_addr - AW'(1);
  assign rd_addr    = AW'(item_i.row) * AW'(COLUMNS) + AW'(item_i.col);

  always_comb begin
    step_col = {1'b0, cur_col_q};
    step_row = {1'b0, cur_row_q};
    case (item_i.op)
      OP_PRINT: step_col = step_col + ColW'(1);
      OP_NEWLINE: begin
        step_col = '0;
        step_row = step_row + RowW'(1);
      end
      OP_BACKSPACE: begin
        if (cur_col_q != '0) begin
          step_col = step_col - ColW'(1);
        end else if (cur_row_q != '0) begin
          step_row = step_row - RowW'(1);
          step_col = ColW'(COLUMNS - 1);
        end
      end
      OP_TAB: step_col = (step_col + ColW'(4)) & ~ColW'(3);
      default: ;
    endcase
    if (step_col >= ColW'(COLUMNS)) begin
      step_col = '0;
      step_row = step_row + RowW'(1);
    end
    step_scroll = (step_row >= RowW'(ROWS));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (last_cnt) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            OP_CLEAR: state_d = ST_FILL;
            OP_READ:  state_d = ST_EMIT;
            default:  state_d = step_scroll ? ST_COPY : ST_EMIT;
          endcase
        end
      end
      ST_COPY: begin
        if (last_cnt) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_FILL;
      ST_FILL: begin
        if (last_cnt) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    cnt_d        = cnt_q;
    wa_d         = wa_q;
    pend_d       = pend_q;
    scroll_d     = scroll_q;
    cell_sel_d   = cell_sel_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_word_d   = out_word_q;
    out_scroll_d = out_scroll_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = cnt_q;
    mem_wd       = blank_word;
    mem_re       = 1'b0;
    mem_ra       = cnt_q;
    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wd = {ResetAttr, CharSpace};
        cnt_d  = last_cnt ? '0 : cnt_q + AW'(1);
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o      = 1'b1;
          cell_sel_d = 1'b0;
          scroll_d   = 1'b0;
          case (item_i.op)
            OP_CLEAR: begin
              cur_col_d = '0;
              cur_row_d = '0;
              cnt_d     = '0;
            end
            OP_READ: begin
              mem_re     = 1'b1;
              mem_ra     = rd_addr;
              cell_sel_d = 1'b1;
            end
            default: begin
              if (item_i.op == OP_PRINT) begin
                mem_we = 1'b1;
                mem_wa = cur_addr;
                mem_wd = {attr_i, item_i.ch};
              end else if (item_i.op == OP_BACKSPACE) begin
                mem_we = 1'b1;
                mem_wa = bs_addr;
              end
              if (step_scroll) begin
                cur_col_d = '0;
                cur_row_d = RW'(ROWS - 1);
                scroll_d  = 1'b1;
                cnt_d     = AW'(COLUMNS);
                pend_d    = 1'b0;
              end else begin
                cur_col_d = CW'(step_col);
                cur_row_d = RW'(step_row);
              end
            end
          endcase
        end
      end
      ST_COPY: begin
        mem_re = 1'b1;
        mem_ra = cnt_q;
        mem_we = pend_q;
        mem_wa = wa_q;
        mem_wd = rdata_q;
        pend_d = 1'b1;
        wa_d   = cnt_q - AW'(COLUMNS);
        cnt_d  = cnt_q + AW'(1);
      end
      ST_DRAIN: begin
        mem_we = 1'b1;
        mem_wa = wa_q;
        mem_wd = rdata_q;
        pend_d = 1'b0;
        cnt_d  = AW'(CellCount - COLUMNS);
      end
      ST_FILL: begin
        mem_we = 1'b1;
        cnt_d  = last_cnt ? '0 : cnt_q + AW'(1);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_col_d    = 7'(cur_col_q);
          out_row_d    = 5'(cur_row_q);
          out_word_d   = cell_sel_q ? rdata_q : 16'd0;
          out_scroll_d = scroll_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      scroll_q    <= 1'b0;
      cell_sel_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      scroll_q    <= scroll_d;
      cell_sel_q  <= cell_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q         <= wa_d;
    out_col_q    <= out_col_d;
    out_row_q    <= out_row_d;
    out_word_q   <= out_word_d;
    out_scroll_q <= out_scroll_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  assign init_busy_o  = (state_q == ST_INIT);
  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign cell_word_o  = out_word_q;
  assign did_scroll_o = out_scroll_q;

  `TCCE_ASSERT_ALWAYS(a_col_range, clk_i, rst_ni, {1'b0, cur_col_q} < ColW'(COLUMNS))
  `TCCE_ASSERT_ALWAYS(a_row_range, clk_i, rst_ni, {1'b0, cur_row_q} < RowW'(ROWS))
  `TCCE_ASSERT_IMPLIES(a_copy_dst, clk_i, rst_ni, (state_q == ST_COPY) && pend_q, wa_q < AW'(CellCount - COLUMNS))
  `TCCE_ASSERT_NEXT(a_emit_beat, clk_i, rst_ni, (state_q == ST_EMIT) && out_free, out_valid_q && (state_q == ST_IDLE))

endmodule

// ----- rtl/core/text_console_cursor_engine.sv -----
// Text console engine: in/out valid-ready channels, one result beat per input beat.
// Holds the attribute register; depends on tcce_pkg, tcce_front, tcce_queue, tcce_back.
//
// An input beat carries mode, char_code, read_row and read_col. Mode 0 prints a
// character or handles newline, backspace and tab; mode 1 clears the screen;
// mode 2 reads one cell. Each beat gives one output beat with the cursor after
// the op, the read cell word (zero outside a read) and a scroll flag.
// The attribute register is written through cfg_we_i/cfg_wdata_i with no wait.
// A simple op passes the op queue, the ST_IDLE and ST_EMIT states and the output
// register before out_valid_o; a new op leaves the two-entry op queue only once
// the back end is idle again, so a stalled receiver holds it back. A scroll walks
// the screen store (one read port, one write port): it copies each row up by one
// and blanks the bottom row. A clear blanks every cell and homes the cursor.
// After reset a fill sweep writes every cell with in_ready_o held low; attribute
// writes are still taken. When the receiver stalls, the result holds in the
// output register, the back end waits, and in_ready_o drops once the queue is full.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::DefColumns,
  parameter int ROWS    = tcce_pkg::DefRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [4:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [15:0] cell_word_o,
  output logic        did_scroll_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import tcce_pkg::*;

  logic [7:0] attr_q;
  logic       push, pop, full, empty, init_busy;
  op_item_t   front_item, back_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ResetAttr;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .queue_full_i (full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .item_o       (front_item)
  );

  tcce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (back_item)
  );

  tcce_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .attr_i       (attr_q),
    .item_valid_i (!empty),
    .item_i       (back_item),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_word_o  (cell_word_o),
    .did_scroll_o (did_scroll_o)
  );

endmodule
